### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock while out of reset
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every clock while out of reset
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dwsu_pkg.sv
package dwsu_pkg;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_STEP = 2'd0,
        CFG_INV_DX_SQ = 2'd1,
        CFG_INV_DZ_SQ = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] TIME_STEP_RST = 32'd4294967;
    localparam logic [CFG_W-1:0] INV_D_SQ_RST  = 32'd42949673;

    // field widths
    localparam int PRESS_W = 32;
    localparam int DAMP_W  = 24;
    localparam int VEL_W   = 14;

    // internal widths
    localparam int E_W       = 40;   // d*dt in U8.32
    localparam int DEN_W     = 41;   // 1 + d*dt in U9.32
    localparam int REM_W     = 41;
    localparam int Q_W       = 33;   // 1/(1+d*dt) in U1.32
    localparam int DIV_STEPS = 33;   // one quotient bit per stage
    localparam int G_W       = 45;
    localparam int S_W       = 53;
    localparam int GS_W      = 97;

    // word carried through the reciprocal stages
    typedef struct packed {
        logic [DEN_W-1:0]          den;
        logic [REM_W-1:0]          rem;
        logic [Q_W-1:0]            quo;
        logic [E_W-1:0]            e;
        logic signed [PRESS_W-1:0] center;
        logic signed [PRESS_W-1:0] prev;
        logic signed [GS_W-1:0]    gs;
    } div_stage_t;

endpackage

### src/damped_wave_stencil_update_unit.sv
// Damped 2-D acoustic wave update, one grid cell per word. Takes a new cell every clock
// cycle while in_stall is low and passes it through six stages of products, then the
// 33-stage restoring divider that forms 1/(1+d*dt), one quotient bit a stage, then three
// stages of coefficient products and the final sum, and then the output register. A
// two-word output buffer lets the pipe keep advancing after out_stall rises until a result
// must go into the skid word; in_stall is high only while that buffer is full.
// Registers: 0 time_step (U0.32), 1 inv_dx_squared (U0.32), 2 inv_dz_squared (U0.32);
// writes to index 3 are dropped and cfg_ready is always high. Registers are meant to be
// written only while the pipe is empty. Results saturate to the 32-bit range and then
// raise overflow.
`include "assert_macros.svh"

module damped_wave_stencil_update_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dwsu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dwsu_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [dwsu_pkg::PRESS_W-1:0]  center_pressure,
    input  logic signed [dwsu_pkg::PRESS_W-1:0]  left_pressure,
    input  logic signed [dwsu_pkg::PRESS_W-1:0]  right_pressure,
    input  logic signed [dwsu_pkg::PRESS_W-1:0]  upper_pressure,
    input  logic signed [dwsu_pkg::PRESS_W-1:0]  lower_pressure,
    input  logic signed [dwsu_pkg::PRESS_W-1:0]  prev_pressure,
    input  logic [dwsu_pkg::DAMP_W-1:0]          damping,
    input  logic [dwsu_pkg::VEL_W-1:0]           velocity,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [dwsu_pkg::PRESS_W-1:0]  next_pressure,
    output logic                                 overflow
);

    localparam int DIV_STEPS = dwsu_pkg::DIV_STEPS;
    localparam int DIV_LAST  = 5 + DIV_STEPS;   // valid index of the last divider stage
    localparam int NSTG      = DIV_LAST + 4;

    // configuration registers
    logic [dwsu_pkg::CFG_W-1:0] time_step_reg;
    logic [dwsu_pkg::CFG_W-1:0] inv_dx_sq_reg;
    logic [dwsu_pkg::CFG_W-1:0] inv_dz_sq_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= dwsu_pkg::TIME_STEP_RST;
            inv_dx_sq_reg <= dwsu_pkg::INV_D_SQ_RST;
            inv_dz_sq_reg <= dwsu_pkg::INV_D_SQ_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                dwsu_pkg::CFG_TIME_STEP: time_step_reg <= cfg_data;
                dwsu_pkg::CFG_INV_DX_SQ: inv_dx_sq_reg <= cfg_data;
                dwsu_pkg::CFG_INV_DZ_SQ: inv_dz_sq_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipe control: the whole pipe advances unless the output buffer is full
    logic            skid_valid_reg;
    logic            skid_valid_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [NSTG-1:0] vld_reg;
    logic            en;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // stage 1: damping and velocity products, second differences
    logic [55:0]        e_prod_next, e_prod_reg;
    logic [45:0]        w_next, w_reg;
    logic signed [34:0] lx_next, lx_reg, lz_next, lz_reg;
    logic signed [31:0] c1_reg, p1_reg;

    assign e_prod_next = 56'(damping) * 56'(time_step_reg);
    assign w_next      = 46'(velocity) * 46'(time_step_reg);
    assign lx_next     = 35'(right_pressure) + 35'(left_pressure) - (35'(center_pressure) <<< 1);
    assign lz_next     = 35'(lower_pressure) + 35'(upper_pressure) - (35'(center_pressure) <<< 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_prod_reg <= e_prod_next;
            w_reg      <= w_next;
            lx_reg     <= lx_next;
            lz_reg     <= lz_next;
            c1_reg     <= center_pressure;
            p1_reg     <= prev_pressure;
        end
    end

    // stage 2: round d*dt, partial products of (c*dt)^2, weighted differences
    logic [dwsu_pkg::E_W-1:0] e_next, e2_reg;
    logic [45:0]              ww_ll_next, ww_lh_next, ww_hh_next;
    logic [45:0]              ww_ll_reg, ww_lh_reg, ww_hh_reg;
    logic signed [67:0]       sx_next, sx_reg, sz_next, sz_reg;
    logic signed [31:0]       c2_reg, p2_reg;

    assign e_next     = dwsu_pkg::E_W'((57'(e_prod_reg) + 57'd32768) >> 16);
    assign ww_ll_next = 46'(w_reg[22:0]) * 46'(w_reg[22:0]);
    assign ww_lh_next = 46'(w_reg[22:0]) * 46'(w_reg[45:23]);
    assign ww_hh_next = 46'(w_reg[45:23]) * 46'(w_reg[45:23]);
    assign sx_next    = 68'(lx_reg) * 68'($signed({1'b0, inv_dx_sq_reg}));
    assign sz_next    = 68'(lz_reg) * 68'($signed({1'b0, inv_dz_sq_reg}));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e2_reg    <= e_next;
            ww_ll_reg <= ww_ll_next;
            ww_lh_reg <= ww_lh_next;
            ww_hh_reg <= ww_hh_next;
            sx_reg    <= sx_next;
            sz_reg    <= sz_next;
            c2_reg    <= c1_reg;
            p2_reg    <= p1_reg;
        end
    end

    // stage 3: (c*dt)^2 and the rounded spatial term
    logic [91:0]                     w2_next, w2_reg;
    logic signed [dwsu_pkg::S_W-1:0] s_next, s3_reg;
    logic [dwsu_pkg::E_W-1:0]        e3_reg;
    logic signed [31:0]              c3_reg, p3_reg;

    assign w2_next = (92'(ww_hh_reg) << 46) + (92'(ww_lh_reg) << 24) + 92'(ww_ll_reg);
    assign s_next  = dwsu_pkg::S_W'((69'(sx_reg) + 69'(sz_reg) + 69'sd32768) >>> 16);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w2_reg <= w2_next;
            s3_reg <= s_next;
            e3_reg <= e2_reg;
            c3_reg <= c2_reg;
            p3_reg <= p2_reg;
        end
    end

    // stage 4: round c^2*dt^2 to Q.16
    logic [dwsu_pkg::G_W-1:0]        g_next, g_reg;
    logic signed [dwsu_pkg::S_W-1:0] s4_reg;
    logic [dwsu_pkg::E_W-1:0]        e4_reg;
    logic signed [31:0]              c4_reg, p4_reg;

    assign g_next = dwsu_pkg::G_W'((93'(w2_reg) + (93'd1 << 47)) >> 48);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_reg  <= g_next;
            s4_reg <= s3_reg;
            e4_reg <= e3_reg;
            c4_reg <= c3_reg;
            p4_reg <= p3_reg;
        end
    end

    // stage 5: partial products of gain times spatial term
    logic [48:0]              pp_ll_next, pp_ll_reg;
    logic signed [49:0]       pp_lh_next, pp_lh_reg;
    logic [47:0]              pp_hl_next, pp_hl_reg;
    logic signed [48:0]       pp_hh_next, pp_hh_reg;
    logic signed [26:0]       s_hi;
    logic [dwsu_pkg::E_W-1:0] e5_reg;
    logic signed [31:0]       c5_reg, p5_reg;

    assign s_hi       = $signed(s4_reg[52:26]);
    assign pp_ll_next = 49'(g_reg[22:0]) * 49'(s4_reg[25:0]);
    assign pp_lh_next = 50'($signed({1'b0, g_reg[22:0]})) * 50'(s_hi);
    assign pp_hl_next = 48'(g_reg[44:23]) * 48'(s4_reg[25:0]);
    assign pp_hh_next = 49'($signed({1'b0, g_reg[44:23]})) * 49'(s_hi);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp_ll_reg <= pp_ll_next;
            pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next;
            pp_hh_reg <= pp_hh_next;
            e5_reg    <= e4_reg;
            c5_reg    <= c4_reg;
            p5_reg    <= p4_reg;
        end
    end

    // stage 6 and divider: sum the gain term, then one quotient bit of 2^64/(2^32+e) a stage
    dwsu_pkg::div_stage_t div_next [0:DIV_STEPS];
    dwsu_pkg::div_stage_t div_reg  [0:DIV_STEPS];

    always_comb
    begin
        logic [dwsu_pkg::REM_W:0] trial;
        div_next[0].den    = dwsu_pkg::DEN_W'(e5_reg) + (41'd1 << 32);
        div_next[0].rem    = 41'd1 << 31;
        div_next[0].quo    = '0;
        div_next[0].e      = e5_reg;
        div_next[0].center = c5_reg;
        div_next[0].prev   = p5_reg;
        div_next[0].gs     = (97'(pp_hh_reg) << 49) + (97'(pp_lh_reg) << 26)
                           + (97'(pp_hl_reg) << 23) + 97'(pp_ll_reg);
        for (int k = 1; k <= DIV_STEPS; k++)
        begin
            div_next[k] = div_reg[k-1];
            trial = {div_reg[k-1].rem, 1'b0};
            if (trial >= 42'(div_reg[k-1].den))
            begin
                div_next[k].rem = dwsu_pkg::REM_W'(trial - 42'(div_reg[k-1].den));
                div_next[k].quo = {div_reg[k-1].quo[dwsu_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                div_next[k].rem = dwsu_pkg::REM_W'(trial);
                div_next[k].quo = {div_reg[k-1].quo[dwsu_pkg::Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k <= DIV_STEPS; k++)
                div_reg[k] <= div_next[k];
        end
    end

    // back stage 1: M/A = 1 - e + r, N/A = 1 - 2r
    logic signed [42:0]                 cm_next, cm_reg;
    logic signed [34:0]                 cn_next, cn_reg;
    logic signed [31:0]                 cb_reg, pb_reg;
    logic signed [dwsu_pkg::GS_W-1:0]   gsb1_reg;

    assign cm_next = (43'd1 << 32) - 43'(div_reg[DIV_STEPS].e) + 43'(div_reg[DIV_STEPS].quo);
    assign cn_next = (35'd1 << 32) - (35'(div_reg[DIV_STEPS].quo) << 1);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cm_reg   <= cm_next;
            cn_reg   <= cn_next;
            cb_reg   <= div_reg[DIV_STEPS].center;
            pb_reg   <= div_reg[DIV_STEPS].prev;
            gsb1_reg <= div_reg[DIV_STEPS].gs;
        end
    end

    // back stage 2: coefficient times pressure, split in halves
    logic signed [53:0]               pcl_next, pch_next, pcl_reg, pch_reg;
    logic signed [49:0]               pnl_next, pnh_next, pnl_reg, pnh_reg;
    logic signed [dwsu_pkg::GS_W-1:0] gsb2_reg;

    assign pcl_next = 54'($signed({1'b0, cm_reg[20:0]})) * 54'(cb_reg);
    assign pch_next = 54'($signed(cm_reg[42:21])) * 54'(cb_reg);
    assign pnl_next = 50'($signed({1'b0, cn_reg[16:0]})) * 50'(pb_reg);
    assign pnh_next = 50'($signed(cn_reg[34:17])) * 50'(pb_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pcl_reg  <= pcl_next;
            pch_reg  <= pch_next;
            pnl_reg  <= pnl_next;
            pnh_reg  <= pnh_next;
            gsb2_reg <= gsb1_reg;
        end
    end

    // back stage 3: full accumulator with the rounding half added
    logic signed [99:0] acc_next, acc_reg;

    assign acc_next = (100'(pch_reg) << 21) + 100'(pcl_reg) + (100'(pnh_reg) << 17)
                    + 100'(pnl_reg) + 100'(gsb2_reg) + (100'd1 << 31);

    always_ff @(posedge clk)
    begin
        if (en)
            acc_reg <= acc_next;
    end

    // round to pressure format and saturate
    logic               fits;
    logic signed [31:0] res_press;
    logic               res_ovf;
    logic               item;

    always_comb
    begin
        fits = (&acc_reg[99:63]) || !(|acc_reg[99:63]);
        if (fits)
        begin
            res_press = $signed(acc_reg[63:32]);
            res_ovf   = 1'b0;
        end
        else
        begin
            res_press = acc_reg[99] ? 32'sh80000000 : 32'sh7fffffff;
            res_ovf   = 1'b1;
        end
    end

    assign item = vld_reg[NSTG-1] && en;

    // output register with one skid word
    logic signed [31:0] out_press_reg, skid_press_reg;
    logic               out_ovf_reg, skid_ovf_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (!out_stall)
                skid_valid_next = 1'b0;
        end
        else if (item)
        begin
            if (!out_valid_reg || !out_stall)
                out_valid_next = 1'b1;
            else
                skid_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (!out_stall)
            begin
                out_press_reg <= skid_press_reg;
                out_ovf_reg   <= skid_ovf_reg;
            end
        end
        else if (item)
        begin
            if (!out_valid_reg || !out_stall)
            begin
                out_press_reg <= res_press;
                out_ovf_reg   <= res_ovf;
            end
            else
            begin
                skid_press_reg <= res_press;
                skid_ovf_reg   <= res_ovf;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign next_pressure = out_press_reg;
    assign overflow      = out_ovf_reg;

    // checks
    `CHK_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid word without output word")
    `CHK_IMPL(a_ovf_saturated, out_valid_reg && out_ovf_reg, out_press_reg == 32'sh7fffffff || out_press_reg == 32'sh80000000, "overflow without saturated value")
    `CHK_IMPL(a_recip_bound, vld_reg[DIV_LAST], div_reg[DIV_STEPS].quo <= (33'd1 << 32), "reciprocal above one")
    `CHK_NEXT(a_pipe_frozen, skid_valid_reg, vld_reg == $past(vld_reg), "pipe moved while buffer full")

endmodule
